[rtl/zotl_pkg.sv]
// ----------------------------------------------------------------------------
// Zone offset transition lookup package
// Shared widths, request kinds, register indexes and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package zotl_pkg;

  // Default number of entries in each transition table.
  localparam int unsigned DEPTH_DEFAULT = 256;

  // Field widths.
  localparam int unsigned INST_W     = 64;
  localparam int unsigned OFFS_W     = 17;
  localparam int unsigned DST_W      = 18;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned REG_ADDR_W = 4;
  localparam int unsigned REG_DATA_W = 32;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_WALL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // Register indexes (word address).
  localparam logic [1:0] REG_WALL_COUNT = 2'd0;
  localparam logic [1:0] REG_STD_COUNT  = 2'd1;
  localparam logic [1:0] REG_BASE_WALL  = 2'd2;
  localparam logic [1:0] REG_BASE_STD   = 2'd3;

  // Largest signed 64-bit instant.
  localparam logic signed [INST_W-1:0] INSTANT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  // Status of the search unit as seen by the sequencer.
  typedef struct packed {
    logic done;
    logic found;
  } srch_stat_t;

  // Bits needed to address a table of the given depth.
  function automatic int unsigned addr_w(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Bits needed to hold a count from zero up to the depth itself.
  function automatic int unsigned cnt_w(input int unsigned depth);
    return $clog2(depth + 1);
  endfunction

endpackage

`default_nettype wire

[rtl/zotl_table.sv]
// ----------------------------------------------------------------------------
// Transition table memory
// One write port and one registered read port; each entry holds an instant
// and the offset in force after it.
// ----------------------------------------------------------------------------
`default_nettype none

module zotl_table #(
  parameter int unsigned DEPTH = zotl_pkg::DEPTH_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [zotl_pkg::addr_w(DEPTH)-1:0]       wr_addr,
  input  logic signed [zotl_pkg::INST_W-1:0]       wr_instant,
  input  logic signed [zotl_pkg::OFFS_W-1:0]       wr_offset,
  input  logic                                     rd_en,
  input  logic [zotl_pkg::addr_w(DEPTH)-1:0]       rd_addr,
  output logic signed [zotl_pkg::INST_W-1:0]       rd_instant,
  output logic signed [zotl_pkg::OFFS_W-1:0]       rd_offset
);
  import zotl_pkg::*;

  logic [INST_W+OFFS_W-1:0] mem [DEPTH];
  logic [INST_W+OFFS_W-1:0] rd_word;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_instant, wr_offset};
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_instant = rd_word[INST_W+OFFS_W-1:OFFS_W];
  assign rd_offset  = rd_word[OFFS_W-1:0];

endmodule

`default_nettype wire

[rtl/zotl_search.sv]
// ----------------------------------------------------------------------------
// Binary search unit
// Shared by all table searches. Each step reads the middle entry and
// compares it against the key; it ends on an equal entry or with the
// insertion point.
// ----------------------------------------------------------------------------
`default_nettype none

module zotl_search #(
  parameter int unsigned DEPTH = zotl_pkg::DEPTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [zotl_pkg::cnt_w(DEPTH)-1:0]     count,
  input  logic signed [zotl_pkg::INST_W-1:0]    key,
  output logic                                  rd_en,
  output logic [zotl_pkg::addr_w(DEPTH)-1:0]    rd_addr,
  input  logic signed [zotl_pkg::INST_W-1:0]    rd_instant,
  output zotl_pkg::srch_stat_t                  stat,
  output logic [zotl_pkg::cnt_w(DEPTH)-1:0]     pos
);
  import zotl_pkg::*;

  localparam int unsigned AW = addr_w(DEPTH);
  localparam int unsigned CW = cnt_w(DEPTH);

  typedef enum logic [3:0] {
    SR_IDLE = 4'b0001,
    SR_TEST = 4'b0010,
    SR_CMP  = 4'b0100,
    SR_DONE = 4'b1000
  } sr_state_t;

  sr_state_t                 state, state_next;
  logic [CW-1:0]             lo, lo_next;
  logic [CW-1:0]             hi1, hi1_next;
  logic [CW-1:0]             count_r;
  logic [AW-1:0]             mid;
  logic signed [INST_W-1:0]  key_r;
  logic                      found, found_next;
  logic [CW-1:0]             pos_next;
  logic [CW:0]               mid_sum;
  logic                      key_lt;
  logic                      key_eq;

  // Middle of the open range [lo, hi1).
  assign mid_sum = {1'b0, lo} + {1'b0, hi1} - (CW+1)'(1);
  assign rd_en   = (state == SR_TEST) && (lo < hi1);
  assign rd_addr = AW'(mid_sum >> 1);

  // The shared compare unit.
  assign key_lt = rd_instant < key_r;
  assign key_eq = rd_instant == key_r;

  // Step control.
  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi1_next   = hi1;
    found_next = found;
    pos_next   = pos;
    case (state)
      SR_IDLE: begin
        if (start) begin
          lo_next    = '0;
          hi1_next   = count;
          found_next = 1'b0;
          state_next = SR_TEST;
        end
      end
      SR_TEST: begin
        if (lo < hi1) begin
          state_next = SR_CMP;
        end else begin
          pos_next   = lo;
          state_next = SR_DONE;
        end
      end
      SR_CMP: begin
        if (key_eq) begin
          found_next = 1'b1;
          pos_next   = CW'(mid);
          state_next = SR_DONE;
        end else if (key_lt) begin
          lo_next    = CW'(mid) + CW'(1);
          state_next = SR_TEST;
        end else begin
          hi1_next   = CW'(mid);
          state_next = SR_TEST;
        end
      end
      SR_DONE: begin
        state_next = SR_IDLE;
      end
      default: begin
        state_next = SR_IDLE;
      end
    endcase
  end

  // State and range registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SR_IDLE;
      found <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
    end
    lo  <= lo_next;
    hi1 <= hi1_next;
    pos <= pos_next;
    if (state == SR_IDLE && start) begin
      key_r   <= key;
      count_r <= count;
    end
    if (rd_en) begin
      mid <= rd_addr;
    end
  end

  assign stat.done  = (state == SR_DONE);
  assign stat.found = found;

  // The entry under compare lies inside the remaining range.
  assert property (@(posedge clk) disable iff (rst)
    (state == SR_CMP) |-> (CW'(mid) < hi1) && (CW'(mid) >= lo))
    else $error("search compare outside the open range");

  // A finished search points no further than one past the last entry.
  assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (pos <= count_r))
    else $error("search position beyond the entry count");

endmodule

`default_nettype wire

[rtl/zone_offset_transition_lookup.sv]
// ----------------------------------------------------------------------------
// Zone offset transition lookup
// Holds a wall table and a standard table of transitions and answers
// offset, next-transition and previous-transition queries by binary search.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on in_valid/in_stall. A load request (kind wall or
// standard) writes one table entry. A query request runs three binary
// searches on one shared search unit (wall table on the instant, standard
// table on the instant, wall table on the instant rounded up), then six
// reads of neighboring entries. A search of a table with n entries takes
// at most ceil(log2(n+1)) steps. The searches and reads take turns on the
// search unit and the single read port of each table. in_stall stays high
// from a query's acceptance until its result is loaded into the output
// register.
// Results leave on out_valid/out_stall from that register; while the
// receiver stalls, the result holds and a following query waits at its final
// step. Until a following query is accepted, loads are still taken.
// Configuration is to be written over the APB port only while no query is
// in flight; the block itself does not enforce this.
// Reset clears the configuration registers, out_valid and the sequencer;
// table contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module zone_offset_transition_lookup #(
  parameter int unsigned TABLE_DEPTH = zotl_pkg::DEPTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [zotl_pkg::KIND_W-1:0]           kind,
  input  logic [zotl_pkg::IDX_W-1:0]            entry_index,
  input  logic signed [zotl_pkg::INST_W-1:0]    entry_instant,
  input  logic signed [zotl_pkg::OFFS_W-1:0]    entry_offset,
  input  logic signed [zotl_pkg::INST_W-1:0]    query_seconds,
  input  logic                                  query_has_fraction,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [zotl_pkg::OFFS_W-1:0]    wall_offset,
  output logic signed [zotl_pkg::OFFS_W-1:0]    standard_offset_now,
  output logic signed [zotl_pkg::DST_W-1:0]     daylight_seconds,
  output logic                                  next_valid,
  output logic signed [zotl_pkg::INST_W-1:0]    next_instant,
  output logic signed [zotl_pkg::OFFS_W-1:0]    next_before,
  output logic signed [zotl_pkg::OFFS_W-1:0]    next_after,
  output logic                                  prev_valid,
  output logic signed [zotl_pkg::INST_W-1:0]    prev_instant,
  output logic signed [zotl_pkg::OFFS_W-1:0]    prev_before,
  output logic signed [zotl_pkg::OFFS_W-1:0]    prev_after,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [zotl_pkg::REG_ADDR_W-1:0]       paddr,
  input  logic [zotl_pkg::REG_DATA_W-1:0]       pwdata,
  output logic [zotl_pkg::REG_DATA_W-1:0]       prdata,
  output logic                                  pready
);
  import zotl_pkg::*;

  localparam int unsigned AW = addr_w(TABLE_DEPTH);
  localparam int unsigned CW = cnt_w(TABLE_DEPTH);
  localparam int unsigned UW = (CW > CNT_W) ? CW : CNT_W;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_WSRCH = 10'b00_0000_0010,
    ST_SSRCH = 10'b00_0000_0100,
    ST_PSRCH = 10'b00_0000_1000,
    ST_RLAST = 10'b00_0001_0000,
    ST_RQ1   = 10'b00_0010_0000,
    ST_RQ    = 10'b00_0100_0000,
    ST_RP1   = 10'b00_1000_0000,
    ST_RP2   = 10'b01_0000_0000,
    ST_FIN   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [CNT_W-1:0]         wall_count;
  logic [CNT_W-1:0]         standard_count;
  logic signed [OFFS_W-1:0] base_wall_offset;
  logic signed [OFFS_W-1:0] base_standard_offset;
  logic                     cfg_we;

  // Query working registers.
  logic signed [INST_W-1:0] t_key;
  logic signed [INST_W-1:0] e_key;
  logic [CW-1:0]            q;
  logic [CW-1:0]            qs;
  logic [CW-1:0]            pe;
  logic                     next_cond;
  logic signed [OFFS_W-1:0] wall_off;
  logic signed [OFFS_W-1:0] std_off;
  logic signed [INST_W-1:0] nx_inst;
  logic signed [OFFS_W-1:0] nx_after;
  logic signed [INST_W-1:0] pv_inst;
  logic signed [OFFS_W-1:0] pv_after;

  // Entries in use, limited to the table depth.
  logic [UW-1:0]            nw_ext;
  logic [UW-1:0]            ns_ext;
  logic [CW-1:0]            nw;
  logic [CW-1:0]            ns;

  // Request handling.
  logic                     in_acc;
  logic                     slot_ok;
  logic                     wall_we;
  logic                     std_we;
  logic                     out_load;
  logic signed [INST_W-1:0] e_calc;

  // Table ports.
  logic                     wall_rd_en;
  logic [AW-1:0]            wall_rd_addr;
  logic signed [INST_W-1:0] wall_rd_inst;
  logic signed [OFFS_W-1:0] wall_rd_off;
  logic                     std_rd_en;
  logic [AW-1:0]            std_rd_addr;
  logic signed [INST_W-1:0] std_rd_inst;
  logic signed [OFFS_W-1:0] std_rd_off;

  // Search unit ports.
  logic                     srch_start;
  logic [CW-1:0]            srch_count;
  logic signed [INST_W-1:0] srch_key;
  logic                     srch_rd_en;
  logic [AW-1:0]            srch_rd_addr;
  logic signed [INST_W-1:0] srch_rd_inst;
  srch_stat_t               srch_stat;
  logic [CW-1:0]            srch_pos;
  logic [CW-1:0]            srch_q;

  // Configuration port: always ready, writes in the access phase.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_count           <= '0;
      standard_count       <= '0;
      base_wall_offset     <= '0;
      base_standard_offset <= '0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_WALL_COUNT: wall_count           <= pwdata[CNT_W-1:0];
        REG_STD_COUNT:  standard_count       <= pwdata[CNT_W-1:0];
        REG_BASE_WALL:  base_wall_offset     <= pwdata[OFFS_W-1:0];
        REG_BASE_STD:   base_standard_offset <= pwdata[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WALL_COUNT: prdata = REG_DATA_W'(wall_count);
      REG_STD_COUNT:  prdata = REG_DATA_W'(standard_count);
      REG_BASE_WALL:  prdata = REG_DATA_W'(base_wall_offset);
      REG_BASE_STD:   prdata = REG_DATA_W'(base_standard_offset);
      default:        prdata = '0;
    endcase
  end

  // Clamp the counts to the table depth.
  assign nw_ext = UW'(wall_count);
  assign ns_ext = UW'(standard_count);
  assign nw = (nw_ext > UW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(nw_ext);
  assign ns = (ns_ext > UW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(ns_ext);

  // Request acceptance and table loads.
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && (state == ST_IDLE);
  assign slot_ok  = 32'(entry_index) < TABLE_DEPTH;
  assign wall_we  = in_acc && (kind == KIND_WALL) && slot_ok;
  assign std_we   = in_acc && (kind == KIND_STD) && slot_ok;

  // Instant rounded up for the previous-transition search.
  assign e_calc = (query_has_fraction && (query_seconds != INSTANT_MAX)) ?
                  query_seconds + 64'sd1 : query_seconds;

  // Search unit hookup.
  assign srch_count   = (state == ST_SSRCH) ? ns : nw;
  assign srch_key     = (state == ST_PSRCH) ? e_key : t_key;
  assign srch_rd_inst = (state == ST_SSRCH) ? std_rd_inst : wall_rd_inst;
  assign srch_q       = srch_stat.found ? srch_pos + CW'(1) : srch_pos;

  // Table read addressing by sequencer step.
  always_comb begin
    wall_rd_en   = 1'b0;
    wall_rd_addr = '0;
    std_rd_en    = 1'b0;
    std_rd_addr  = '0;
    case (state)
      ST_WSRCH, ST_PSRCH: begin
        wall_rd_en   = srch_rd_en;
        wall_rd_addr = srch_rd_addr;
      end
      ST_SSRCH: begin
        std_rd_en   = srch_rd_en;
        std_rd_addr = srch_rd_addr;
      end
      ST_RLAST: begin
        wall_rd_en   = 1'b1;
        wall_rd_addr = AW'(nw - CW'(1));
        std_rd_en    = 1'b1;
        std_rd_addr  = AW'(qs - CW'(1));
      end
      ST_RQ1: begin
        wall_rd_en   = 1'b1;
        wall_rd_addr = AW'(q - CW'(1));
      end
      ST_RQ: begin
        wall_rd_en   = 1'b1;
        wall_rd_addr = AW'(q);
      end
      ST_RP1: begin
        wall_rd_en   = 1'b1;
        wall_rd_addr = AW'(pe - CW'(1));
      end
      ST_RP2: begin
        wall_rd_en   = 1'b1;
        wall_rd_addr = AW'(pe - CW'(2));
      end
      default: ;
    endcase
  end

  // The result register takes a new result when empty or being drained.
  assign out_load = (state == ST_FIN) && (!out_valid || !out_stall);

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && (kind == KIND_QUERY)) begin
          state_next = ST_WSRCH;
        end
      end
      ST_WSRCH: begin
        if (srch_stat.done) begin
          state_next = ST_SSRCH;
        end
      end
      ST_SSRCH: begin
        if (srch_stat.done) begin
          state_next = ST_PSRCH;
        end
      end
      ST_PSRCH: begin
        if (srch_stat.done) begin
          state_next = ST_RLAST;
        end
      end
      ST_RLAST: state_next = ST_RQ1;
      ST_RQ1:   state_next = ST_RQ;
      ST_RQ:    state_next = ST_RP1;
      ST_RP1:   state_next = ST_RP2;
      ST_RP2:   state_next = ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      srch_start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      srch_start <= (state_next != state) &&
                    ((state_next == ST_WSRCH) || (state_next == ST_SSRCH) ||
                     (state_next == ST_PSRCH));
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Query datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      t_key <= query_seconds;
      e_key <= e_calc;
    end
    if (srch_stat.done) begin
      case (state)
        ST_WSRCH: q  <= srch_q;
        ST_SSRCH: qs <= srch_q;
        ST_PSRCH: pe <= srch_pos;
        default: ;
      endcase
    end
    case (state)
      ST_RQ1: begin
        next_cond <= (nw != '0) && (t_key < wall_rd_inst);
        std_off   <= (qs == '0) ? base_standard_offset : std_rd_off;
      end
      ST_RQ: begin
        wall_off <= (q == '0) ? base_wall_offset : wall_rd_off;
      end
      ST_RP1: begin
        nx_inst  <= wall_rd_inst;
        nx_after <= wall_rd_off;
      end
      ST_RP2: begin
        pv_inst  <= wall_rd_inst;
        pv_after <= wall_rd_off;
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      wall_offset         <= wall_off;
      standard_offset_now <= std_off;
      daylight_seconds    <= DST_W'(wall_off) - DST_W'(std_off);
      if (next_cond && (q < nw)) begin
        next_valid   <= 1'b1;
        next_instant <= nx_inst;
        next_before  <= wall_off;
        next_after   <= nx_after;
      end else begin
        next_valid   <= 1'b0;
        next_instant <= '0;
        next_before  <= '0;
        next_after   <= '0;
      end
      if (pe != '0) begin
        prev_valid   <= 1'b1;
        prev_instant <= pv_inst;
        prev_before  <= (pe >= CW'(2)) ? wall_rd_off : base_wall_offset;
        prev_after   <= pv_after;
      end else begin
        prev_valid   <= 1'b0;
        prev_instant <= '0;
        prev_before  <= '0;
        prev_after   <= '0;
      end
    end
  end

  zotl_table #(
    .DEPTH(TABLE_DEPTH)
  ) u_wall_table (
    .clk        (clk),
    .wr_en      (wall_we),
    .wr_addr    (AW'(entry_index)),
    .wr_instant (entry_instant),
    .wr_offset  (entry_offset),
    .rd_en      (wall_rd_en),
    .rd_addr    (wall_rd_addr),
    .rd_instant (wall_rd_inst),
    .rd_offset  (wall_rd_off)
  );

  zotl_table #(
    .DEPTH(TABLE_DEPTH)
  ) u_std_table (
    .clk        (clk),
    .wr_en      (std_we),
    .wr_addr    (AW'(entry_index)),
    .wr_instant (entry_instant),
    .wr_offset  (entry_offset),
    .rd_en      (std_rd_en),
    .rd_addr    (std_rd_addr),
    .rd_instant (std_rd_inst),
    .rd_offset  (std_rd_off)
  );

  zotl_search #(
    .DEPTH(TABLE_DEPTH)
  ) u_search (
    .clk        (clk),
    .rst        (rst),
    .start      (srch_start),
    .count      (srch_count),
    .key        (srch_key),
    .rd_en      (srch_rd_en),
    .rd_addr    (srch_rd_addr),
    .rd_instant (srch_rd_inst),
    .stat       (srch_stat),
    .pos        (srch_pos)
  );

  // The search unit only finishes while the sequencer waits on it.
  assert property (@(posedge clk) disable iff (rst)
    srch_stat.done |->
      ((state == ST_WSRCH) || (state == ST_SSRCH) || (state == ST_PSRCH)))
    else $error("search finished outside a search step");

  // A new result appears only from the final step of a query.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result raised without a finished query");

endmodule

`default_nettype wire
